>>> rtl/cht_pkg.sv
package cht_pkg;

  localparam int KEY_W    = 31;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 6;

  typedef enum logic {
    FN_INSERT = 1'b0,
    FN_SEARCH = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

endpackage

>>> rtl/cht_req_if.sv
interface cht_req_if
  import cht_pkg::*;
;
  logic             valid;
  logic             ready;
  func_t            func;
  logic [KEY_W-1:0] key;

  modport source (output valid, output func, output key, input ready);
  modport sink (input valid, input func, input key, output ready);
endinterface

>>> rtl/cht_rsp_if.sv
interface cht_rsp_if
  import cht_pkg::*;
;
  logic              valid;
  logic              ready;
  status_t           status;
  logic [SLOT_W-1:0] node_slot;

  modport source (output valid, output status, output node_slot, input ready);
  modport sink (input valid, input status, input node_slot, output ready);
endinterface

>>> rtl/chained_hash_table.sv
// Hash table of 31-bit keys with separate chaining over a fixed node pool.
// req carries one word per operation (func: insert or search, key); rsp returns
// one word per operation (status, node_slot). Both are valid/ready channels.
// Work is one operation at a time: req.ready is high only while the engine idles.
// The key is multiplied by a fixed reciprocal of BUCKETS as it is accepted.
// From accept to rsp.valid the engine forms the bucket index from the quotient
// (MOD), reads the bucket head (HEAD), takes it (HWAIT), visits each chain node
// in WALK (node key/link memory, one read a cycle), then for an insert writes
// back in LINK and FIX, and posts the result in RESULT. A walk visits at most
// POOL_NODES nodes; a refused insert goes from HEAD straight to RESULT.
// The next request is accepted the cycle after the result posts; RESULT waits
// while an earlier result is still held by a stalled receiver.
// The result sits in an output register, so the next request is accepted while
// it waits; a stalled receiver holds the engine only when a second result is
// ready to post. Reset clears the bucket valid bits and the allocation count at
// once; node memories need no clearing since only allocated nodes are linked.
module chained_hash_table
  import cht_pkg::*;
#(
  parameter int BUCKETS    = 10,
  parameter int POOL_NODES = 64
) (
  input  logic      clk,
  input  logic      rst,
  cht_req_if.sink   req,
  cht_rsp_if.source rsp
);

  localparam int PTR_W = $clog2(POOL_NODES + 1);
  localparam int IDX_W = $clog2(POOL_NODES);
  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SH    = KEY_W + $clog2(BUCKETS);
  localparam int RCP_W = KEY_W + 1;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_NODES);

  typedef enum logic [2:0] {
    IDLE, MOD, HEAD, HWAIT, WALK, LINK, FIX, RESULT
  } state_t;

  state_t state;

  // memories
  logic [KEY_W-1:0] key_mem  [POOL_NODES];
  logic [PTR_W-1:0] link_mem [POOL_NODES];
  logic [PTR_W-1:0] head_mem [BUCKETS];
  logic [BUCKETS-1:0] head_vld;

  logic [KEY_W-1:0] key_q;
  logic [PTR_W-1:0] link_q;
  logic [PTR_W-1:0] head_q;
  logic             head_ok;

  // operation registers
  func_t            op_func;
  logic [KEY_W-1:0] op_key;
  logic [KEY_W+RCP_W-1:0] prod;
  logic [BW-1:0]    rem;
  logic [PTR_W-1:0] cur;
  logic [PTR_W-1:0] prev;
  logic [PTR_W-1:0] nodes_used;
  status_t          res_status;
  logic [PTR_W-1:0] res_slot;

  logic              out_valid;
  status_t           out_status;
  logic [SLOT_W-1:0] out_slot;

  logic [KEY_W-1:0]   quo;
  logic [KEY_W-1:0]   rem_full;
  logic [BW-1:0]      bucket;
  logic [PTR_W-1:0]   cur_head;
  logic               advance;
  logic               node_rd_en;
  logic [PTR_W-1:0]   node_rd_addr;
  logic               link_we;
  logic [PTR_W-1:0]   link_waddr;
  logic [PTR_W-1:0]   link_wdata;
  logic               head_we;
  logic [PTR_W+SLOT_W-1:0] slot_wide;

  assign req.ready     = (state == IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.node_slot = out_slot;

  assign bucket    = rem;
  assign cur_head  = head_ok ? head_q : NULL_PTR;
  assign slot_wide = {{SLOT_W{1'b0}}, res_slot};

  // quotient from the reciprocal product; the remainder is what it leaves of the key
  assign quo      = KEY_W'(prod >> SH);
  assign rem_full = op_key - quo * KEY_W'(BUCKETS);

  always_comb begin
    if (op_func == FN_SEARCH) begin
      advance = (key_q != op_key);
    end else begin
      advance = (key_q < op_key);
    end
  end

  always_comb begin
    node_rd_en   = 1'b0;
    node_rd_addr = link_q;
    case (state)
      HWAIT: begin
        node_rd_en   = (cur_head != NULL_PTR);
        node_rd_addr = cur_head;
      end
      WALK: begin
        node_rd_en   = advance && (link_q != NULL_PTR);
        node_rd_addr = link_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    link_we    = 1'b0;
    link_waddr = nodes_used;
    link_wdata = cur;
    head_we    = 1'b0;
    case (state)
      LINK: begin
        link_we = 1'b1;
      end
      FIX: begin
        // hook the new node in behind prev, or at the head of the chain
        if (prev == NULL_PTR) begin
          head_we = 1'b1;
        end else begin
          link_we    = 1'b1;
          link_waddr = prev;
          link_wdata = nodes_used;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_rd_en) begin
      key_q  <= key_mem[node_rd_addr[IDX_W-1:0]];
      link_q <= link_mem[node_rd_addr[IDX_W-1:0]];
    end
    if (state == LINK) begin
      key_mem[nodes_used[IDX_W-1:0]] <= op_key;
    end
    if (link_we) begin
      link_mem[link_waddr[IDX_W-1:0]] <= link_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state == HEAD) begin
      head_q  <= head_mem[bucket];
      head_ok <= head_vld[bucket];
    end
    if (head_we) begin
      head_mem[bucket] <= nodes_used;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      out_valid  <= 1'b0;
      nodes_used <= '0;
      head_vld   <= '0;
    end else begin
      if (out_valid && rsp.ready && state != RESULT) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req.valid) begin
            op_func <= req.func;
            op_key  <= req.key;
            prod    <= req.key * RECIP;
            state   <= MOD;
          end
        end
        MOD: begin
          rem   <= rem_full[BW-1:0];
          state <= HEAD;
        end
        HEAD: begin
          prev <= NULL_PTR;
          if (op_func == FN_INSERT && nodes_used == NULL_PTR) begin
            res_status <= ST_FULL;
            res_slot   <= '0;
            state      <= RESULT;
          end else begin
            state <= HWAIT;
          end
        end
        HWAIT: begin
          cur <= cur_head;
          if (cur_head != NULL_PTR) begin
            state <= WALK;
          end else if (op_func == FN_SEARCH) begin
            res_status <= ST_MISSING;
            res_slot   <= '0;
            state      <= RESULT;
          end else begin
            state <= LINK;
          end
        end
        WALK: begin
          if (op_func == FN_SEARCH) begin
            if (!advance) begin
              res_status <= ST_FOUND;
              res_slot   <= cur;
              state      <= RESULT;
            end else if (link_q == NULL_PTR) begin
              res_status <= ST_MISSING;
              res_slot   <= '0;
              state      <= RESULT;
            end else begin
              cur <= link_q;
            end
          end else begin
            if (advance) begin
              prev <= cur;
              cur  <= link_q;
              if (link_q == NULL_PTR) begin
                state <= LINK;
              end
            end else begin
              state <= LINK;
            end
          end
        end
        LINK: begin
          state <= FIX;
        end
        FIX: begin
          if (prev == NULL_PTR) begin
            head_vld[bucket] <= 1'b1;
          end
          res_status <= ST_INSERTED;
          res_slot   <= nodes_used;
          nodes_used <= nodes_used + 1'b1;
          state      <= RESULT;
        end
        RESULT: begin
          // post once the output register is free
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_slot   <= slot_wide[SLOT_W-1:0];
            state      <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
  import cht_pkg::*;

  localparam int NBUCKET    = 10;
  localparam int NPOOL      = 64;
  localparam int NIL        = NPOOL;
  localparam int RAND_ITEMS = 800;
  localparam int CALM_ITEMS = 100;
  localparam int DRAIN_WAIT = 120;
  localparam int STUCK_MAX  = 3000;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } answer_t;

  typedef struct packed {
    func_t            func;
    logic [KEY_W-1:0] key;
    logic             typed;
    answer_t          ans;
  } row_t;

  logic clk;
  logic rst;

  cht_req_if req_ch ();
  cht_rsp_if rsp_ch ();

  chained_hash_table #(
    .BUCKETS    (NBUCKET),
    .POOL_NODES (NPOOL)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow copy of the table
  int unsigned      bucket_first [NBUCKET];
  logic [KEY_W-1:0] pool_key     [NPOOL];
  int unsigned      pool_next    [NPOOL];
  int unsigned      nodes_alloc;

  answer_t          answers_due [$];
  logic [KEY_W-1:0] keys_seen   [$];
  row_t             plan        [$];

  int mismatches = 0;
  int stuck      = 0;
  int hold_left  = 0;
  bit calm       = 1'b0;
  answer_t want;

  function automatic answer_t chain_table_apply(func_t f, logic [KEY_W-1:0] k);
    int unsigned b, cur, prev, steps, slot;
    answer_t ans;
    b = int'({1'b0, k}) % NBUCKET;
    ans = '{ST_MISSING, '0};
    if (f == FN_INSERT) begin
      if (nodes_alloc >= NPOOL) begin
        ans = '{ST_FULL, '0};
      end else begin
        slot = nodes_alloc;
        nodes_alloc++;
        pool_key[slot] = k;
        cur = bucket_first[b];
        prev = NIL;
        steps = 0;
        // stop ahead of the first node whose key is not smaller
        while (cur < NIL && pool_key[cur] < k && steps < NPOOL) begin
          prev = cur;
          cur = pool_next[cur];
          steps++;
        end
        pool_next[slot] = cur;
        if (prev >= NIL) bucket_first[b] = slot;
        else pool_next[prev] = slot;
        ans = '{ST_INSERTED, SLOT_W'(slot)};
      end
    end else begin
      cur = bucket_first[b];
      steps = 0;
      while (cur < NIL && steps < NPOOL) begin
        if (pool_key[cur] == k) begin
          ans = '{ST_FOUND, SLOT_W'(cur)};
          break;
        end
        cur = pool_next[cur];
        steps++;
      end
    end
    return ans;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r <= 3 && keys_seen.size() != 0)
      return keys_seen[$urandom_range(0, keys_seen.size() - 1)];
    if (r <= 5)
      return KEY_W'(10 * $urandom_range(0, 40) + 3);
    if (r == 6 && keys_seen.size() != 0)
      return keys_seen[$urandom_range(0, keys_seen.size() - 1)] + KEY_W'(10 * $urandom_range(1, 3));
    return KEY_W'($urandom);
  endfunction

  task automatic send_word(func_t f, logic [KEY_W-1:0] k, logic typed, answer_t typed_ans);
    answer_t ans;
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func  <= f;
    req_ch.key   <= k;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    ans = chain_table_apply(f, k);
    answers_due.push_back(typed ? typed_ans : ans);
    if (f == FN_INSERT) keys_seen.push_back(k);
  endtask

  initial begin : drive
    func_t f;
    logic [KEY_W-1:0] k;
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.func  = FN_INSERT;
    req_ch.key   = '0;
    rsp_ch.ready = 1'b0;
    for (int i = 0; i < NBUCKET; i++) bucket_first[i] = NIL;
    nodes_alloc = 0;

    plan.push_back('{FN_SEARCH, 31'd0,          1'b1, '{ST_MISSING,  6'd0}});
    plan.push_back('{FN_SEARCH, 31'h7FFF_FFFF,  1'b1, '{ST_MISSING,  6'd0}});
    plan.push_back('{FN_INSERT, 31'd0,          1'b1, '{ST_INSERTED, 6'd0}});
    plan.push_back('{FN_INSERT, 31'h7FFF_FFFF,  1'b1, '{ST_INSERTED, 6'd1}});
    plan.push_back('{FN_SEARCH, 31'd0,          1'b1, '{ST_FOUND,    6'd0}});
    plan.push_back('{FN_SEARCH, 31'h7FFF_FFFF,  1'b1, '{ST_FOUND,    6'd1}});
    plan.push_back('{FN_INSERT, 31'd10,         1'b0, '{ST_INSERTED, 6'd0}});
    plan.push_back('{FN_INSERT, 31'd10,         1'b0, '{ST_INSERTED, 6'd0}});
    plan.push_back('{FN_SEARCH, 31'd10,         1'b0, '{ST_INSERTED, 6'd0}});
    plan.push_back('{FN_INSERT, 31'd30,         1'b0, '{ST_INSERTED, 6'd0}});
    plan.push_back('{FN_INSERT, 31'd20,         1'b0, '{ST_INSERTED, 6'd0}});
    plan.push_back('{FN_INSERT, 31'd0,          1'b0, '{ST_INSERTED, 6'd0}});
    plan.push_back('{FN_SEARCH, 31'd0,          1'b0, '{ST_INSERTED, 6'd0}});
    plan.push_back('{FN_SEARCH, 31'd40,         1'b0, '{ST_INSERTED, 6'd0}});
    plan.push_back('{FN_SEARCH, 31'd25,         1'b1, '{ST_MISSING,  6'd0}});
    plan.push_back('{FN_INSERT, 31'd2147483640, 1'b0, '{ST_INSERTED, 6'd0}});
    plan.push_back('{FN_SEARCH, 31'd2147483640, 1'b0, '{ST_INSERTED, 6'd0}});
    plan.push_back('{FN_INSERT, 31'd5,          1'b0, '{ST_INSERTED, 6'd0}});
    plan.push_back('{FN_SEARCH, 31'd15,         1'b0, '{ST_INSERTED, 6'd0}});
    plan.push_back('{FN_SEARCH, 31'h5555_5555,  1'b0, '{ST_INSERTED, 6'd0}});
    plan.push_back('{FN_INSERT, 31'h2AAA_AAAA,  1'b0, '{ST_INSERTED, 6'd0}});
    plan.push_back('{FN_SEARCH, 31'h2AAA_AAAA,  1'b0, '{ST_INSERTED, 6'd0}});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_word(plan[i].func, plan[i].key, plan[i].typed, plan[i].ans);

    // fill the pool early, then mostly walk chains
    for (int i = 0; i < RAND_ITEMS; i++) begin
      calm = (i >= RAND_ITEMS - CALM_ITEMS);
      f = ($urandom_range(0, 99) < (i < 200 ? 45 : 20)) ? FN_INSERT : FN_SEARCH;
      k = pick_key();
      send_word(f, k, 1'b0, '{ST_INSERTED, 6'd0});
    end
    req_ch.valid <= 1'b0;

    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    mismatches += answers_due.size();
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // receiver stalls in short bursts
  always @(posedge clk) begin
    if (calm) begin
      rsp_ch.ready <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 11) == 0) begin
      hold_left <= $urandom_range(0, 7);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: status %0d node_slot %0d",
                   rsp_ch.status, rsp_ch.node_slot);
      end else begin
        want = answers_due.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.node_slot !== want.slot) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d node_slot %0d, got status %0d node_slot %0d",
                     want.status, want.slot, rsp_ch.status, rsp_ch.node_slot);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_MAX) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

endmodule
